// ===== src/iptrk_pkg.sv =====
// Package for the in-flight page write tracker.
// Holds command and error codes and the fixed bank field width; no dependencies.
`default_nettype none

package iptrk_pkg;

    localparam int BANK_W = 6;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_END     = 2'd1,
        CMD_EQUAL   = 2'd2,
        CMD_EARLIER = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_BUSY = 2'd1,
        ERR_FREE = 2'd2
    } err_t;

endpackage

`default_nettype wire

// ===== src/iptrk_table.sv =====
// Slot table: one synchronous memory of (bank, page) entries with a registered read.
// Depends on iptrk_pkg; per-entry valid bits make unwritten entries read as free.
`default_nettype none

module iptrk_table
    import iptrk_pkg::*;
#(
    parameter int SLOTS     = 32,
    parameter int BANKS     = 32,
    parameter int PAGE_BITS = 24,
    parameter int ADDR_W    = 5
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [BANK_W-1:0]    wr_bank,
    input  wire logic [PAGE_BITS-1:0] wr_page,
    output logic      [BANK_W-1:0]    rd_bank,
    output logic      [PAGE_BITS-1:0] rd_page
);

    localparam logic [BANK_W-1:0] BANK_FREE = BANK_W'(BANKS);
    localparam int                ENTRY_W   = BANK_W + PAGE_BITS;

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_valid_reg;
    logic [SLOTS-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_bank, wr_page};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_bank = rd_valid_reg ? rd_data_reg[ENTRY_W-1:PAGE_BITS] : BANK_FREE;
    assign rd_page = rd_valid_reg ? rd_data_reg[PAGE_BITS-1:0] : '0;

endmodule

`default_nettype wire

// ===== src/inflight_page_write_tracker_top.sv =====
// Top level of the in-flight page write tracker: command sequencer and result register.
// Depends on iptrk_pkg and iptrk_table.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: command, slot, bank, page.
//   Output channel (out_valid / out_stall) returns one transaction per input: found, error.
//   One command is worked on at a time; in_stall is high while it is in progress.
//   Start and end read the slot entry on accept and write it back in state READ, then
//   deliver the result from state DONE; READ is skipped if the slot is out of range
//   or a start carries page zero.
//   Queries read every slot in turn through the one table read port, one entry per
//   cycle in state SCAN, then deliver the result from state DONE.
//   The result register holds a finished transaction while out_stall is high; the next
//   command may already be accepted and worked on, and waits to deliver only if the
//   register is still occupied when it finishes.
//   Reset empties every slot (bank BANKS, page zero) at once through per-slot valid
//   bits and drops any transaction in progress or pending at the output.
`default_nettype none

module inflight_page_write_tracker_top
    import iptrk_pkg::*;
#(
    parameter int SLOTS     = 32,
    parameter int BANKS     = 32,
    parameter int PAGE_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [4:0]  slot,
    input  wire logic [4:0]  bank,
    input  wire logic [23:0] page,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [1:0]       error
);

    localparam int                ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int                IDX_W     = $clog2(SLOTS + 1);
    localparam logic [BANK_W-1:0] BANK_FREE = BANK_W'(BANKS);
    localparam logic [8:0]        SLOTS_L   = 9'(SLOTS);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [ADDR_W-1:0]     slot_reg;
    logic [BANK_W-1:0]     bank_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  found_reg;
    err_t                  err_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    err_t                  out_error_reg;

    cmd_t                  in_cmd;
    logic [31:0]           page_ext;
    logic [PAGE_BITS-1:0]  in_page;
    logic [7:0]            slot_ext;
    logic [ADDR_W-1:0]     in_addr;
    logic                  slot_ok;
    logic                  out_free;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [BANK_W-1:0]     wr_bank;
    logic [PAGE_BITS-1:0]  wr_page;
    logic [BANK_W-1:0]     rd_bank;
    logic [PAGE_BITS-1:0]  rd_page;
    logic                  entry_busy;
    logic                  entry_hit;

    assign in_cmd   = cmd_t'(command);
    assign page_ext = {8'd0, page};
    assign in_page  = page_ext[PAGE_BITS-1:0];
    assign slot_ext = {3'd0, slot};
    assign in_addr  = slot_ext[ADDR_W-1:0];
    assign slot_ok  = ({4'd0, slot} < SLOTS_L);
    assign out_free = !out_valid_reg || !out_stall;

    assign entry_busy = (rd_page != '0);
    assign entry_hit  = (rd_bank == bank_reg) &&
                        ((cmd_reg == CMD_EQUAL) ? (rd_page == page_reg)
                                                : (rd_page < page_reg));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = in_addr;
        wr_en   = 1'b0;
        wr_bank = bank_reg;
        wr_page = page_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_EQUAL || in_cmd == CMD_EARLIER)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    else
                    begin
                        rd_en = slot_ok;
                    end
                end
            end
            ST_READ:
            begin
                if (cmd_reg == CMD_START)
                begin
                    wr_en = !entry_busy;
                end
                else
                begin
                    wr_en   = entry_busy;
                    wr_bank = BANK_FREE;
                    wr_page = '0;
                end
                rd_addr = slot_reg;
            end
            ST_SCAN:
            begin
                rd_en   = (idx_reg != IDX_LAST);
                rd_addr = idx_reg[ADDR_W-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    iptrk_table #(
        .SLOTS     (SLOTS),
        .BANKS     (BANKS),
        .PAGE_BITS (PAGE_BITS),
        .ADDR_W    (ADDR_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_bank (wr_bank),
        .wr_page (wr_page),
        .rd_bank (rd_bank),
        .rd_page (rd_page)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_START;
            slot_reg      <= '0;
            bank_reg      <= '0;
            page_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            err_reg       <= ERR_OK;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_error_reg <= ERR_OK;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= in_cmd;
                        slot_reg  <= in_addr;
                        bank_reg  <= {1'b0, bank};
                        page_reg  <= in_page;
                        found_reg <= 1'b0;
                        err_reg   <= ERR_OK;
                        idx_reg   <= IDX_W'(1);
                        if (in_cmd == CMD_EQUAL || in_cmd == CMD_EARLIER)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (slot_ok && !(in_cmd == CMD_START && in_page == '0))
                        begin
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_READ:
                begin
                    if (cmd_reg == CMD_START && entry_busy)
                    begin
                        err_reg <= ERR_BUSY;
                    end
                    else if (cmd_reg == CMD_END && !entry_busy)
                    begin
                        err_reg <= ERR_FREE;
                    end
                    state_reg <= ST_DONE;
                end
                ST_SCAN:
                begin
                    if (entry_hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_error_reg <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign error     = out_error_reg;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the in-flight page write tracker: directed and random tests.
// Keeps its own copy of the slot table to predict every result; needs iptrk_pkg and
// inflight_page_write_tracker_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iptrk_pkg::*;

    localparam int SLOTS       = 32;
    localparam int BANKS       = 32;
    localparam int PAGE_BITS   = 24;
    localparam int CLK_PERIOD  = 10;
    localparam int RESET_LEN   = 11;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = SLOTS + 8;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic found;
        err_t err;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = 2'd0;
    logic [4:0]  slot = 5'd0;
    logic [4:0]  bank = 5'd0;
    logic [23:0] page = 24'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [1:0]  error;

    logic [BANK_W-1:0]    slot_owner_bank [SLOTS];
    logic [PAGE_BITS-1:0] slot_owner_page [SLOTS];
    outcome_t             awaited_replies[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int max_burst   = 4;
    int max_gap     = 3;
    int stall_mode  = 0;
    int stall_phase = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    inflight_page_write_tracker_top #(
        .SLOTS     (SLOTS),
        .BANKS     (BANKS),
        .PAGE_BITS (PAGE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .slot      (slot),
        .bank      (bank),
        .page      (page),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .error     (error)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise the current stall pattern
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        stall_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                1:       out_stall <= ($urandom_range(0, 99) < 20);
                2:       out_stall <= ($urandom_range(0, 99) < 70);
                3:       out_stall <= ((stall_phase % 7) < 3);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result with nothing awaited: found=%0d error=%0d", found, error);
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, found);
                    error_count++;
                end
                if (error !== want.err)
                begin
                    $error("error: expected %0d, actual %0d", want.err, error);
                    error_count++;
                end
            end
        end
    end

    function automatic void clear_slot_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_owner_bank[i] = BANK_W'(BANKS);
            slot_owner_page[i] = '0;
        end
    endfunction

    function automatic outcome_t apply_command(cmd_t c, logic [4:0] s, logic [4:0] b,
                                               logic [23:0] p);
        outcome_t o;
        logic [PAGE_BITS-1:0] pg;
        o.found = 1'b0;
        o.err   = ERR_OK;
        pg      = PAGE_BITS'(p);
        case (c)
            CMD_START:
                if (s < SLOTS && pg != 0)
                begin
                    if (slot_owner_page[s] != 0)
                        o.err = ERR_BUSY;
                    else
                    begin
                        slot_owner_bank[s] = BANK_W'(b);
                        slot_owner_page[s] = pg;
                    end
                end
            CMD_END:
                if (s < SLOTS)
                begin
                    if (slot_owner_page[s] == 0)
                        o.err = ERR_FREE;
                    else
                    begin
                        slot_owner_bank[s] = BANK_W'(BANKS);
                        slot_owner_page[s] = '0;
                    end
                end
            default:
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_owner_bank[i] == BANK_W'(b))
                    begin
                        if (c == CMD_EQUAL ? slot_owner_page[i] == pg
                                           : slot_owner_page[i] < pg)
                            o.found = 1'b1;
                    end
                end
        endcase
        return o;
    endfunction

    function automatic logic [4:0] pick_slot(bit want_busy);
        int candidates[$];
        for (int i = 0; i < SLOTS; i++)
        begin
            if ((slot_owner_page[i] != 0) == want_busy)
                candidates.push_back(i);
        end
        if (candidates.size() == 0)
            return 5'($urandom_range(0, SLOTS - 1));
        return 5'(candidates[$urandom_range(0, candidates.size() - 1)]);
    endfunction

    function automatic logic [4:0] pick_bank();
        if ($urandom_range(0, 99) < 70)
            return 5'($urandom_range(0, 3));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [23:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 24'd0;
        if (r < 10)
            return 24'hFFFFFF;
        if (r < 70)
            return 24'($urandom_range(1, 20));
        return 24'($urandom);
    endfunction

    task automatic send_item(input cmd_t c, input logic [4:0] s, input logic [4:0] b,
                             input logic [23:0] p);
        int gap;
        if (burst_left == 0)
        begin
            if (max_gap > 0)
            begin
                gap = $urandom_range(1, max_gap);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, max_burst);
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= c;
        slot     <= s;
        bank     <= b;
        page     <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        awaited_replies.push_back(apply_command(c, s, b, p));
    endtask

    task automatic send_random_item();
        int          r;
        logic [4:0]  s;
        logic [4:0]  b;
        logic [23:0] p;
        r = $urandom_range(0, 99);
        s = 5'($urandom_range(0, SLOTS - 1));
        b = pick_bank();
        p = pick_page();
        if (r < 30)
        begin
            if ($urandom_range(0, 9) < 8)
                s = pick_slot(1'b0);
            send_item(CMD_START, s, b, p);
        end
        else if (r < 55)
        begin
            if ($urandom_range(0, 99) < 85)
                s = pick_slot(1'b1);
            send_item(CMD_END, s, b, p);
        end
        else if (r < 80)
        begin
            s = pick_slot(1'b1);
            if ($urandom_range(0, 99) < 60 && slot_owner_page[s] != 0)
            begin
                b = 5'(slot_owner_bank[s]);
                p = 24'(slot_owner_page[s]);
            end
            send_item(CMD_EQUAL, s, b, p);
        end
        else
        begin
            s = pick_slot(1'b1);
            if ($urandom_range(0, 99) < 50 && slot_owner_page[s] != 0)
            begin
                b = 5'(slot_owner_bank[s]);
                p = 24'(slot_owner_page[s]) + 24'($urandom_range(0, 2));
            end
            send_item(CMD_EARLIER, s, b, p);
        end
    endtask

    task automatic test_directed();
        stall_mode = 0;
        max_gap    = 2;
        send_item(CMD_START,   5'd0,  5'd0,  24'd1);
        send_item(CMD_START,   5'd31, 5'd31, 24'hFFFFFF);
        send_item(CMD_START,   5'd0,  5'd7,  24'd9);
        send_item(CMD_START,   5'd5,  5'd3,  24'd0);
        send_item(CMD_END,     5'd5,  5'd3,  24'd0);
        send_item(CMD_EQUAL,   5'd0,  5'd0,  24'd1);
        send_item(CMD_EQUAL,   5'd0,  5'd31, 24'hFFFFFF);
        send_item(CMD_EQUAL,   5'd0,  5'd31, 24'hFFFFFE);
        send_item(CMD_EQUAL,   5'd0,  5'd0,  24'd0);
        send_item(CMD_EARLIER, 5'd0,  5'd31, 24'hFFFFFF);
        send_item(CMD_EARLIER, 5'd0,  5'd0,  24'd2);
        send_item(CMD_EARLIER, 5'd0,  5'd0,  24'd1);
        send_item(CMD_EARLIER, 5'd0,  5'd5,  24'hFFFFFF);
        send_item(CMD_END,     5'd0,  5'd0,  24'd0);
        send_item(CMD_END,     5'd0,  5'd0,  24'd0);
        send_item(CMD_END,     5'd31, 5'd31, 24'hFFFFFF);
        send_item(CMD_EARLIER, 5'd0,  5'd31, 24'hFFFFFF);
        send_item(CMD_EQUAL,   5'd0,  5'd31, 24'hFFFFFF);
    endtask

    task automatic test_random_mixed(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                max_gap    = $urandom_range(0, 12);
                max_burst  = $urandom_range(1, 8);
            end
            send_random_item();
        end
    endtask

    task automatic test_full_table(input int rounds);
        int order[$];
        for (int r = 0; r < rounds; r++)
        begin
            stall_mode = r % 4;
            max_gap    = (r % 2) ? 5 : 0;
            for (int s = 0; s < SLOTS; s++)
            begin
                if (slot_owner_page[s] == 0)
                    send_item(CMD_START, 5'(s), 5'($urandom_range(0, 3)),
                              24'($urandom_range(1, 40)));
            end
            for (int q = 0; q < 30; q++)
                send_item(q % 2 ? CMD_EARLIER : CMD_EQUAL, 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 4)), 24'($urandom_range(0, 42)));
            order.delete();
            for (int s = 0; s < SLOTS; s++)
                order.push_back(s);
            order.shuffle();
            foreach (order[k])
                send_item(CMD_END, 5'(order[k]), pick_bank(), pick_page());
        end
    endtask

    task automatic test_long_holdoff(input int count);
        stall_mode = 1;
        max_gap    = 0;
        hold_req   = 1'b1;
        for (int n = 0; n < count; n++)
            send_random_item();
    endtask

    task automatic test_no_idle(input int count);
        stall_mode = 0;
        max_gap    = 0;
        for (int n = 0; n < count; n++)
            send_random_item();
    endtask

    initial
    begin
        clear_slot_table();
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mixed(1000);
        test_full_table(4);
        test_long_holdoff(150);
        test_no_idle(300);

        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
